@@ hw/rtl/sgr_pkg.sv @@
// types, constants and color tables for the ansi sgr foreground color decoder
// depends on nothing; imported by sgr_decode, ansi_sgr_color_decoder_unit and the testbench
package sgr_pkg;

    // one sgr parameter item
    typedef struct packed {
        logic [15:0] param_value;
        logic        seq_start;
    } sgr_item_t;

    // one color change item
    typedef struct packed {
        logic       change_kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] swatch_slot;
    } sgr_result_t;

    // what the next parameter is expected to be
    typedef enum logic [5:0] {
        MODE_CTRL   = 6'b000001,
        MODE_FGTYPE = 6'b000010,
        MODE_IDX    = 6'b000100,
        MODE_RED    = 6'b001000,
        MODE_GREEN  = 6'b010000,
        MODE_BLUE   = 6'b100000
    } sgr_mode_t;

    localparam logic CHANGE_RGB    = 1'b0;
    localparam logic CHANGE_SWATCH = 1'b1;

    localparam logic [15:0] SGR_RESET     = 16'd0;
    localparam logic [15:0] SGR_FG_EXT    = 16'd38;
    localparam logic [15:0] SGR_FG_DEF    = 16'd39;
    localparam logic [15:0] SGR_DARK_LO   = 16'd30;
    localparam logic [15:0] SGR_DARK_HI   = 16'd37;
    localparam logic [15:0] SGR_LIGHT_LO  = 16'd90;
    localparam logic [15:0] SGR_LIGHT_HI  = 16'd97;
    localparam logic [15:0] SGR_SWATCH_LO = 16'd110;
    localparam logic [15:0] SGR_SWATCH_HI = 16'd113;
    localparam logic [15:0] EXT_TYPE_RGB  = 16'd2;
    localparam logic [15:0] EXT_TYPE_IDX  = 16'd5;

    localparam logic [7:0] IDX_CUBE_BASE = 8'd16;
    localparam logic [7:0] IDX_GREY_BASE = 8'd232;

    // {red, green, blue}
    function automatic logic [23:0] dark_color(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = {8'd0,   8'd0,   8'd0};
            3'd1:    c = {8'd205, 8'd49,  8'd49};
            3'd2:    c = {8'd13,  8'd188, 8'd121};
            3'd3:    c = {8'd229, 8'd229, 8'd16};
            3'd4:    c = {8'd36,  8'd114, 8'd200};
            3'd5:    c = {8'd188, 8'd63,  8'd188};
            3'd6:    c = {8'd17,  8'd168, 8'd205};
            default: c = {8'd229, 8'd229, 8'd229};
        endcase
        return c;
    endfunction

    function automatic logic [23:0] light_color(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = {8'd102, 8'd102, 8'd102};
            3'd1:    c = {8'd241, 8'd76,  8'd76};
            3'd2:    c = {8'd35,  8'd209, 8'd139};
            3'd3:    c = {8'd245, 8'd245, 8'd67};
            3'd4:    c = {8'd59,  8'd142, 8'd234};
            3'd5:    c = {8'd214, 8'd112, 8'd214};
            3'd6:    c = {8'd41,  8'd184, 8'd219};
            default: c = {8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    // cube level 0..5 scaled by 51
    function automatic logic [7:0] cube_level(input logic [2:0] lvl);
        logic [7:0] c;
        case (lvl)
            3'd0:    c = 8'd0;
            3'd1:    c = 8'd51;
            3'd2:    c = 8'd102;
            3'd3:    c = 8'd153;
            3'd4:    c = 8'd204;
            3'd5:    c = 8'd255;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/sgr_decode.sv @@
// sgr parameter decoder: expected-parameter state, held components, color lookup
// depends on sgr_pkg
module sgr_decode
    import sgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  sgr_item_t   item,
    output logic        has_result,
    output sgr_result_t result
);

    sgr_mode_t  mode_reg, mode_next, mode_eff;
    logic [7:0] held_red_reg, held_red_next;
    logic [7:0] held_green_reg, held_green_next;

    logic [15:0] v;
    logic [7:0]  v8;
    logic        is_byte;

    // 256-color index path
    logic [7:0]  cube_c;
    logic [13:0] prod36;
    logic [15:0] prod6;
    logic [2:0]  q36;
    logic [5:0]  q6;
    logic [5:0]  g_lvl;
    logic [7:0]  b_lvl;
    logic [4:0]  grey_off;
    logic [7:0]  grey;
    logic [23:0] idx_rgb;
    logic        idx_ok;

    assign v       = item.param_value;
    assign v8      = v[7:0];
    assign is_byte = (v[15:8] == 8'd0);

    // c/36 as (c*57)>>11 and c/6 as (c*171)>>10, exact for c below 216
    assign cube_c   = v8 - IDX_CUBE_BASE;
    assign prod36   = 14'(cube_c) * 14'd57;
    assign prod6    = 16'(cube_c) * 16'd171;
    assign q36      = prod36[13:11];
    assign q6       = prod6[15:10];
    assign g_lvl    = q6 - ((6'(q36) << 2) + (6'(q36) << 1));
    assign b_lvl    = cube_c - ((8'(q6) << 2) + (8'(q6) << 1));
    assign grey_off = 5'(v8 - IDX_GREY_BASE);
    assign grey     = ((8'(grey_off) << 3) + (8'(grey_off) << 1)) + 8'd8;

    always_comb
    begin
        idx_ok  = is_byte;
        idx_rgb = '0;
        if (v8 < 8'd8)
        begin
            idx_rgb = dark_color(v8[2:0]);
        end
        else if (v8 < 8'd16)
        begin
            idx_rgb = light_color(v8[2:0]);
        end
        else if (v8 < IDX_GREY_BASE)
        begin
            idx_rgb = {cube_level(q36), cube_level(g_lvl[2:0]), cube_level(b_lvl[2:0])};
        end
        else
        begin
            idx_rgb = {grey, grey, grey};
        end
    end

    assign mode_eff = item.seq_start ? MODE_CTRL : mode_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        has_result      = 1'b0;
        result          = '0;
        if (fire)
        begin
            mode_next = MODE_CTRL;
        end
        case (mode_eff)
            MODE_FGTYPE:
            begin
                if (fire && v == EXT_TYPE_RGB)
                begin
                    mode_next = MODE_RED;
                end
                else if (fire && v == EXT_TYPE_IDX)
                begin
                    mode_next = MODE_IDX;
                end
            end
            MODE_IDX:
            begin
                has_result                          = idx_ok;
                result.change_kind                  = CHANGE_RGB;
                {result.red, result.green, result.blue} = idx_rgb;
            end
            MODE_RED:
            begin
                if (fire && is_byte)
                begin
                    held_red_next = v8;
                    mode_next     = MODE_GREEN;
                end
            end
            MODE_GREEN:
            begin
                if (fire && is_byte)
                begin
                    held_green_next = v8;
                    mode_next       = MODE_BLUE;
                end
            end
            MODE_BLUE:
            begin
                has_result         = is_byte;
                result.change_kind = CHANGE_RGB;
                result.red         = held_red_reg;
                result.green       = held_green_reg;
                result.blue        = v8;
            end
            default:
            begin
                // control type, also covers illegal mode codes
                if (v == SGR_RESET || v == SGR_FG_DEF)
                begin
                    has_result         = 1'b1;
                    result.change_kind = CHANGE_SWATCH;
                    result.swatch_slot = 2'd0;
                end
                else if (v >= SGR_DARK_LO && v <= SGR_DARK_HI)
                begin
                    has_result = 1'b1;
                    {result.red, result.green, result.blue} = dark_color(v8[2:0] - 3'd6);
                end
                else if (v >= SGR_LIGHT_LO && v <= SGR_LIGHT_HI)
                begin
                    has_result = 1'b1;
                    {result.red, result.green, result.blue} = light_color(v8[2:0] - 3'd2);
                end
                else if (v >= SGR_SWATCH_LO && v <= SGR_SWATCH_HI)
                begin
                    has_result         = 1'b1;
                    result.change_kind = CHANGE_SWATCH;
                    result.swatch_slot = v8[1:0] - 2'd2;
                end
                else if (fire && v == SGR_FG_EXT)
                begin
                    mode_next = MODE_FGTYPE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_CTRL;
            held_red_reg   <= '0;
            held_green_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
        end
    end

endmodule

@@ hw/rtl/ansi_sgr_color_decoder_unit.sv @@
// top level of the ansi sgr foreground color decoder: input register, decoder, result register
// depends on sgr_pkg and sgr_decode
//
// Decodes a stream of numeric SGR parameters, one item per cycle, into foreground
// color changes (RGB from the 16-entry palette, the 6x6x6 cube, the grey ramp or a
// 38;2;r;g;b triple, or a swatch slot for 0, 39 and 110..113). An item flagged with
// seq_start returns the decoder to the control-type state before it is decoded.
// Each item gives zero or one result. Throughput is one item per cycle with no
// bubbles while result_stall is low; a result passes the input register, then the
// result register, before it shows on the output. The input register stalls only
// while it holds an item and the result register is full and stalled, so the
// output stall reaches item_stall through one gate.
module ansi_sgr_color_decoder_unit
    import sgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  sgr_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output sgr_result_t result
);

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    sgr_item_t   s1_item_reg;
    logic        s1_fire;
    logic        in_accept;

    // decoder outputs
    logic        dec_has_result;
    sgr_result_t dec_result;

    // result stage
    logic        out_valid_reg, out_valid_next;
    sgr_result_t out_item_reg;
    logic        out_free;

    // result register can take a new item this cycle
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign in_accept  = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= item;
        end
    end

    // mode and held components advance only when the item leaves the input stage
    sgr_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .item       (s1_item_reg),
        .has_result (dec_has_result),
        .result     (dec_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = dec_has_result;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && dec_has_result)
        begin
            out_item_reg <= dec_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`ifndef SYNTHESIS
    // the input side only stalls when an item is parked in the input stage
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg)
        else $error("item_stall without a held item");

    // a swatch change carries no color, an rgb change carries slot 0
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.change_kind == CHANGE_SWATCH)
            ? ({result.red, result.green, result.blue} == 24'd0)
            : (result.swatch_slot == 2'd0)))
        else $error("result fields inconsistent with change kind");

    // a new result appears only after an item left the input stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_fire))
        else $error("result without a decoded item");
`endif

endmodule

@@ dv/ansi_sgr_color_decoder_unit_tb.sv @@
// testbench for ansi_sgr_color_decoder_unit: directed table, then random sgr sequences,
// checked against typed rows or a local predictor, with random gaps and stalls on both sides
// depends on sgr_pkg and the ansi_sgr_color_decoder_unit rtl
module ansi_sgr_color_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgr_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS   = 1350;
    localparam int HOLD_CYCLES    = 48;     // long receiver hold-off
    localparam int BURST_ITEMS    = 16;     // items offered back to back during the hold-off
    localparam int SETTLE_CYCLES  = 8;      // settle time after draining, with margin
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving on either side

    localparam int COMPONENT_MAX  = 255;    // largest 8-bit index or rgb component
    localparam int CUBE_STEP      = 51;
    localparam int GREY_STEP      = 10;
    localparam int GREY_OFFSET    = 8;
    localparam int PALETTE_SPLIT  = 8;      // 8-bit index: dark below, light from here to 15

    // {red, green, blue}
    localparam logic [23:0] DARK_RGB [8] = '{
        {8'd0,   8'd0,   8'd0},   {8'd205, 8'd49,  8'd49},
        {8'd13,  8'd188, 8'd121}, {8'd229, 8'd229, 8'd16},
        {8'd36,  8'd114, 8'd200}, {8'd188, 8'd63,  8'd188},
        {8'd17,  8'd168, 8'd205}, {8'd229, 8'd229, 8'd229}};
    localparam logic [23:0] LIGHT_RGB [8] = '{
        {8'd102, 8'd102, 8'd102}, {8'd241, 8'd76,  8'd76},
        {8'd35,  8'd209, 8'd139}, {8'd245, 8'd245, 8'd67},
        {8'd59,  8'd142, 8'd234}, {8'd214, 8'd112, 8'd214},
        {8'd41,  8'd184, 8'd219}, {8'd255, 8'd255, 8'd255}};

    // one row of the directed table; color is only meaningful when typed is set
    typedef struct {
        logic [15:0] value;
        bit          start;
        bit          typed;
        bit          hit;
        sgr_result_t color;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    sgr_item_t   item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    sgr_result_t result;

    // predictor state, mirrors the decoder after every accepted item
    sgr_mode_t   fg_mode = MODE_CTRL;
    logic [7:0]  held_red = '0;
    logic [7:0]  held_green = '0;

    sgr_result_t   color_q [$];     // color changes still owed by the block
    directed_row_t directed_rows [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  colors_checked = 0;
    int  swatch_seen = 0;
    int  input_stall_cycles = 0;
    int  quiet_cycles = 0;
    int  burst_left = 0;
    bit  steady = 1'b0;             // both sides run with no idling
    bit  hold_off_req = 1'b0;       // sender asks the receiver for one long hold-off

    ansi_sgr_color_decoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic sgr_result_t rgb_change(input int r, input int g, input int b);
        sgr_result_t c;
        c = '0;
        c.change_kind = CHANGE_RGB;
        c.red = r[7:0];
        c.green = g[7:0];
        c.blue = b[7:0];
        return c;
    endfunction

    function automatic sgr_result_t swatch_change(input int slot);
        sgr_result_t c;
        c = '0;
        c.change_kind = CHANGE_SWATCH;
        c.swatch_slot = slot[1:0];
        return c;
    endfunction

    function automatic sgr_result_t palette_change(input logic [23:0] rgb);
        return rgb_change(rgb[23:16], rgb[15:8], rgb[7:0]);
    endfunction

    // advance the predictor by one parameter; returns 1 when a color change is due
    function automatic bit decode_param(input sgr_item_t it, output sgr_result_t color);
        logic [15:0] v;
        sgr_mode_t   m;
        bit          hit;
        int          c;
        int          y;
        v = it.param_value;
        m = it.seq_start ? MODE_CTRL : fg_mode;
        fg_mode = MODE_CTRL;
        hit = 1'b0;
        color = '0;
        case (m)
            MODE_FGTYPE:
            begin
                if (v == EXT_TYPE_RGB)
                    fg_mode = MODE_RED;
                else if (v == EXT_TYPE_IDX)
                    fg_mode = MODE_IDX;
            end
            MODE_IDX:
            begin
                hit = 1'b1;
                if (v < PALETTE_SPLIT)
                    color = palette_change(DARK_RGB[v[2:0]]);
                else if (v < IDX_CUBE_BASE)
                    color = palette_change(LIGHT_RGB[v[2:0]]);
                else if (v < IDX_GREY_BASE)
                begin
                    c = int'(v) - int'(IDX_CUBE_BASE);
                    color = rgb_change((c / 36) * CUBE_STEP, ((c / 6) % 6) * CUBE_STEP,
                                       (c % 6) * CUBE_STEP);
                end
                else if (v <= COMPONENT_MAX)
                begin
                    y = (int'(v) - int'(IDX_GREY_BASE)) * GREY_STEP + GREY_OFFSET;
                    color = rgb_change(y, y, y);
                end
                else
                    hit = 1'b0;
            end
            MODE_RED:
            begin
                if (v <= COMPONENT_MAX)
                begin
                    held_red = v[7:0];
                    fg_mode = MODE_GREEN;
                end
            end
            MODE_GREEN:
            begin
                if (v <= COMPONENT_MAX)
                begin
                    held_green = v[7:0];
                    fg_mode = MODE_BLUE;
                end
            end
            MODE_BLUE:
            begin
                if (v <= COMPONENT_MAX)
                begin
                    hit = 1'b1;
                    color = rgb_change(held_red, held_green, v[7:0]);
                end
            end
            default:
            begin
                // control type: plain colors, swatches, or the start of an extended color
                if (v == SGR_RESET || v == SGR_FG_DEF)
                begin
                    hit = 1'b1;
                    color = swatch_change(0);
                end
                else if (v >= SGR_DARK_LO && v <= SGR_DARK_HI)
                begin
                    hit = 1'b1;
                    color = palette_change(DARK_RGB[int'(v - SGR_DARK_LO)]);
                end
                else if (v >= SGR_LIGHT_LO && v <= SGR_LIGHT_HI)
                begin
                    hit = 1'b1;
                    color = palette_change(LIGHT_RGB[int'(v - SGR_LIGHT_LO)]);
                end
                else if (v >= SGR_SWATCH_LO && v <= SGR_SWATCH_HI)
                begin
                    hit = 1'b1;
                    color = swatch_change(int'(v - SGR_SWATCH_LO));
                end
                else if (v == SGR_FG_EXT)
                    fg_mode = MODE_FGTYPE;
            end
        endcase
        return hit;
    endfunction

    function automatic sgr_item_t sgr_param(input int value, input bit start);
        sgr_item_t it;
        it.param_value = value[15:0];
        it.seq_start = start;
        return it;
    endfunction

    function automatic void add_row(input int value, input bit start, input bit typed,
                                    input bit hit, input sgr_result_t color);
        directed_row_t row;
        row.value = value[15:0];
        row.start = start;
        row.typed = typed;
        row.hit = hit;
        row.color = color;
        directed_rows.push_back(row);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // offer one item and hold it until accepted; expected color is typed in or predicted
    task automatic send_param(input sgr_item_t it, input bit typed, input bit hit,
                              input sgr_result_t color);
        int          gap;
        bit          pred_hit;
        sgr_result_t pred_color;
        if (steady || burst_left > 0)
            gap = 0;
        else
            gap = pick_gap();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // accepted at this edge
        items_sent++;
        pred_hit = decode_param(it, pred_color);
        if (typed)
        begin
            pred_hit = hit;
            pred_color = color;
        end
        if (pred_hit)
            color_q.push_back(pred_color);
    endtask

    // drop valid and wait until every owed color change has come out
    task automatic drain_colors();
        @(negedge clk);
        item_valid <= 1'b0;
        while (color_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_component();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        else if (roll < 20)
            return COMPONENT_MAX;
        else if (roll < 92)
            return $urandom_range(0, COMPONENT_MAX);
        return $urandom_range(COMPONENT_MAX + 1, 65535);
    endfunction

    function automatic int pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return $urandom_range(0, IDX_CUBE_BASE - 1);
        else if (roll < 35)
        begin
            // boundaries of the cube and grey ramp
            case ($urandom_range(0, 3))
                0:       return IDX_CUBE_BASE;
                1:       return IDX_GREY_BASE - 1;
                2:       return IDX_GREY_BASE;
                default: return COMPONENT_MAX;
            endcase
        end
        else if (roll < 88)
            return $urandom_range(0, COMPONENT_MAX);
        return $urandom_range(COMPONENT_MAX + 1, 65535);
    endfunction

    function automatic int pick_ctrl();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return $urandom_range(0, 1) ? SGR_RESET : SGR_FG_DEF;
        else if (roll < 30)
            return SGR_DARK_LO + $urandom_range(0, 7);
        else if (roll < 48)
            return SGR_LIGHT_LO + $urandom_range(0, 7);
        else if (roll < 60)
            return SGR_SWATCH_LO + $urandom_range(0, 3);
        else if (roll < 85)
            return $urandom_range(0, 127);
        return $urandom_range(0, 65535);
    endfunction

    // one random sgr sequence: mostly well formed, some truncated, restarted or noise
    task automatic send_random_sequence();
        sgr_item_t seq [$];
        int        kind;
        int        keep;
        kind = $urandom_range(0, 99);
        if (kind < 22)
            seq.push_back(sgr_param(pick_ctrl(), 1'b0));
        else if (kind < 47)
        begin
            seq.push_back(sgr_param(SGR_FG_EXT, 1'b0));
            seq.push_back(sgr_param(EXT_TYPE_IDX, 1'b0));
            seq.push_back(sgr_param(pick_index(), 1'b0));
        end
        else if (kind < 72)
        begin
            seq.push_back(sgr_param(SGR_FG_EXT, 1'b0));
            seq.push_back(sgr_param(EXT_TYPE_RGB, 1'b0));
            seq.push_back(sgr_param(pick_component(), 1'b0));
            seq.push_back(sgr_param(pick_component(), 1'b0));
            seq.push_back(sgr_param(pick_component(), 1'b0));
        end
        else if (kind < 80)
        begin
            // extended color with a random type, mostly an unknown one
            seq.push_back(sgr_param(SGR_FG_EXT, 1'b0));
            seq.push_back(sgr_param($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 65535), 1'b0));
        end
        else if (kind < 90)
        begin
            // truncated triple or index (an index may be complete), the next sequence picks up mid-way
            seq.push_back(sgr_param(SGR_FG_EXT, 1'b0));
            seq.push_back(sgr_param($urandom_range(0, 1) ? EXT_TYPE_RGB : EXT_TYPE_IDX,
                                    1'b0));
            seq.push_back(sgr_param(pick_component(), 1'b0));
            seq.push_back(sgr_param(pick_component(), 1'b0));
            keep = $urandom_range(1, 3);
            while (seq.size() > keep)
                void'(seq.pop_back());
        end
        else
            seq.push_back(sgr_param($urandom_range(0, 65535), $urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
            seq[0].seq_start = 1'b1;
        // occasional restart in the middle of a sequence
        if ($urandom_range(0, 19) == 0)
            seq[$urandom_range(0, seq.size() - 1)].seq_start = 1'b1;
        foreach (seq[i])
            send_param(seq[i], 1'b0, 1'b0, '0);
    endtask

    // receiver: random stalls, no stalls in steady stretches, one long hold-off on request
    initial
    begin
        int stall_left;
        int roll;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
            end
            else if (stall_left > 0 && !steady)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                roll = $urandom_range(0, 99);
                if (steady || roll < 55)
                    stall_left = 0;
                else if (roll < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(5, 30);
            end
        end
    end

    // result checker: every accepted color change against the oldest one owed
    always @(posedge clk)
    begin
        sgr_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (color_q.size() == 0)
            begin
                $error("unexpected color change: kind %0d rgb %0d,%0d,%0d slot %0d",
                       result.change_kind, result.red, result.green, result.blue,
                       result.swatch_slot);
                fail_count++;
            end
            else
            begin
                want = color_q.pop_front();
                colors_checked++;
                if (want.change_kind == CHANGE_SWATCH)
                    swatch_seen++;
                if (result.change_kind !== want.change_kind)
                begin
                    $error("change_kind: expected %0d, got %0d", want.change_kind,
                           result.change_kind);
                    fail_count++;
                end
                if (result.red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, result.red);
                    fail_count++;
                end
                if (result.green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, result.green);
                    fail_count++;
                end
                if (result.blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, result.blue);
                    fail_count++;
                end
                if (result.swatch_slot !== want.swatch_slot)
                begin
                    $error("swatch_slot: expected %0d, got %0d", want.swatch_slot,
                           result.swatch_slot);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: nothing moving on either side for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_stall)
                input_stall_cycles++;
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d color changes still owed", color_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // main sequence: reset, directed table, random sequences with pressure points, drain
    initial
    begin
        bit hold_done;
        bit pause_done;
        int seq_count;
        hold_done = 1'b0;
        pause_done = 1'b0;
        seq_count = 0;

        // control-type values, extremes and the plain swatches
        add_row(SGR_RESET,     1'b1, 1'b1, 1'b1, swatch_change(0));
        add_row(SGR_FG_DEF,    1'b0, 1'b1, 1'b1, swatch_change(0));
        add_row(SGR_DARK_LO,   1'b0, 1'b1, 1'b1, rgb_change(0, 0, 0));
        add_row(SGR_DARK_HI,   1'b0, 1'b1, 1'b1, rgb_change(229, 229, 229));
        add_row(SGR_LIGHT_HI,  1'b0, 1'b1, 1'b1, rgb_change(255, 255, 255));
        add_row(SGR_SWATCH_HI, 1'b0, 1'b1, 1'b1, swatch_change(3));
        add_row(16'hFFFF,      1'b0, 1'b1, 1'b0, '0);
        // 8-bit index at the top of the grey ramp, which is accepted
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(EXT_TYPE_IDX,  1'b0, 1'b1, 1'b0, '0);
        add_row(COMPONENT_MAX, 1'b0, 1'b1, 1'b1, rgb_change(238, 238, 238));
        // 8-bit index past 255: dropped
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(EXT_TYPE_IDX,  1'b0, 1'b1, 1'b0, '0);
        add_row(256,           1'b0, 1'b1, 1'b0, '0);
        // direct triple with full-scale and zero components
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(EXT_TYPE_RGB,  1'b0, 1'b1, 1'b0, '0);
        add_row(COMPONENT_MAX, 1'b0, 1'b1, 1'b0, '0);
        add_row(0,             1'b0, 1'b1, 1'b0, '0);
        add_row(COMPONENT_MAX, 1'b0, 1'b1, 1'b1, rgb_change(255, 0, 255));
        // red component too large, then the decoder is idle again
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(EXT_TYPE_RGB,  1'b0, 1'b1, 1'b0, '0);
        add_row(256,           1'b0, 1'b1, 1'b0, '0);
        add_row(SGR_SWATCH_LO, 1'b0, 1'b1, 1'b1, swatch_change(0));
        // unknown extended type
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(7,             1'b0, 1'b1, 1'b0, '0);
        // new sequence in the middle of an extended color
        add_row(SGR_FG_EXT,    1'b0, 1'b1, 1'b0, '0);
        add_row(SGR_LIGHT_LO + 1, 1'b1, 1'b1, 1'b1, rgb_change(241, 76, 76));
        // cube entry, left to the predictor
        add_row(SGR_FG_EXT,    1'b0, 1'b0, 1'b0, '0);
        add_row(EXT_TYPE_IDX,  1'b0, 1'b0, 1'b0, '0);
        add_row(100,           1'b0, 1'b0, 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_param(sgr_param(directed_rows[i].value, directed_rows[i].start),
                       directed_rows[i].typed, directed_rows[i].hit,
                       directed_rows[i].color);

        while (items_sent < RANDOM_ITEMS + directed_rows.size())
        begin
            // short stretches with no idling on either side
            steady = (seq_count % 50) < 5;
            if (!hold_done && items_sent >= 400)
            begin
                // receiver holds off while palette colors keep coming, filling the block
                hold_done = 1'b1;
                steady = 1'b0;
                burst_left = BURST_ITEMS;
                hold_off_req = 1'b1;
                for (int k = 0; k < BURST_ITEMS; k++)
                    send_param(sgr_param(SGR_DARK_LO + (k % 8), 1'b0), 1'b0, 1'b0, '0);
            end
            if (!pause_done && items_sent >= 800)
            begin
                pause_done = 1'b1;
                drain_colors();
            end
            send_random_sequence();
            seq_count++;
        end
        steady = 1'b0;

        drain_colors();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d items sent, %0d color changes checked (%0d swatch)",
                 items_sent, colors_checked, swatch_seen);
        $display("summary: input stalled for %0d cycles, %0d mismatches",
                 input_stall_cycles, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
